[rtl/core/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

  // storage geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OCC_BITS  = $clog2(DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [OCC_BITS-1:0]  occ_t;

  // request codes; the two codes above peek back are no-ops
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5
  } mode_e;

  // operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD        = 3'd0,
    CELL_SHIFT_RIGHT = 3'd1,
    CELL_SHIFT_LEFT  = 3'd2,
    CELL_APPEND      = 3'd3,
    CELL_TRIM        = 3'd4
  } cdq_op_e;

endpackage

`default_nettype wire

[rtl/core/cdq_cell.sv]
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cdq_op_e op_i,
  input  wire word_t   new_data_i,
  input  wire word_t   left_data_i,
  input  wire logic    left_occ_i,
  input  wire word_t   right_data_i,
  input  wire logic    right_occ_i,
  output word_t        data_o,
  output logic         occ_o,
  output logic         last_o
);

  word_t data_q, data_d;
  logic  occ_q, occ_d;
  logic  slot_free;

  // first empty cell of the row takes an appended item
  assign slot_free = !occ_q && left_occ_i;
  // last occupied cell holds the back of the queue
  assign last_o    = occ_q && !right_occ_i;

  // next cell contents from the broadcast operation
  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    case (op_i)
      CELL_SHIFT_RIGHT: begin
        data_d = left_data_i;
        occ_d  = left_occ_i;
      end
      CELL_SHIFT_LEFT: begin
        data_d = right_data_i;
        occ_d  = right_occ_i;
      end
      CELL_APPEND: begin
        if (slot_free) begin
          data_d = new_data_i;
          occ_d  = 1'b1;
        end
      end
      CELL_TRIM: begin
        if (last_o) begin
          occ_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;

endmodule

`default_nettype wire

[rtl/core/circular_deque.sv]
`default_nettype none

// Double-ended queue of up to 16 signed 32-bit words. Each item is a request
// (push, pop or peek at the front or back) and returns one result item with a
// success flag, the word read (zero for pushes and failed requests) and the
// occupancy after the request. Entries live in a row of cells that shift
// toward the back on a push at the front and toward the front on a pop at the
// front; the back end is found from the cells' occupied flags. One item is
// taken every cycle unless the input is stalled, and its result reaches the
// output register in the cycle after acceptance; the row updates at once, so a
// stalled output holds up the input only while the output register is full.

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [2:0]                  mode_i,
  input  wire logic signed [WORD_BITS-1:0] push_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic signed [WORD_BITS-1:0]      read_value_o,
  output logic [OCC_BITS-1:0]              occupancy_o
);

  logic            accept;
  logic            full, empty;
  cdq_op_e         op, cell_op;
  logic            ok_d;
  word_t           rd_d;
  word_t           tail_word;
  occ_t            count_q, count_d;
  logic            out_valid_q;
  logic            ok_q;
  word_t           rd_q;
  occ_t            occ_out_q;
  word_t           cell_data [DEPTH];
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_last;

  // handshake: stall only while a finished result is still held
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == occ_t'(DEPTH));
  assign empty = (count_q == '0);

  // back word: and-or over the cell that flags itself last
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | ({WORD_BITS{cell_last[i]}} & cell_data[i]);
    end
  end

  // request decode
  always_comb begin
    op      = CELL_HOLD;
    ok_d    = 1'b0;
    rd_d    = '0;
    count_d = count_q;
    case (mode_e'(mode_i))
      MODE_PUSH_FRONT: begin
        if (!full) begin
          op      = CELL_SHIFT_RIGHT;
          ok_d    = 1'b1;
          count_d = count_q + occ_t'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (!full) begin
          op      = CELL_APPEND;
          ok_d    = 1'b1;
          count_d = count_q + occ_t'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (!empty) begin
          op      = CELL_SHIFT_LEFT;
          ok_d    = 1'b1;
          rd_d    = cell_data[0];
          count_d = count_q - occ_t'(1);
        end
      end
      MODE_POP_BACK: begin
        if (!empty) begin
          op      = CELL_TRIM;
          ok_d    = 1'b1;
          rd_d    = tail_word;
          count_d = count_q - occ_t'(1);
        end
      end
      MODE_PEEK_FRONT: begin
        if (!empty) begin
          ok_d = 1'b1;
          rd_d = cell_data[0];
        end
      end
      MODE_PEEK_BACK: begin
        if (!empty) begin
          ok_d = 1'b1;
          rd_d = tail_word;
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_op = accept ? op : CELL_HOLD;

  // row of storage cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_data, right_data;
    logic  left_occ, right_occ;

    if (i == 0) begin : g_head
      assign left_data = push_value_i;
      assign left_occ  = 1'b1;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .new_data_i   (push_value_i),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .last_o       (cell_last[i])
    );
  end

  // occupancy and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result item register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      rd_q      <= rd_d;
      occ_out_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_value_o = rd_q;
  assign occupancy_o  = occ_out_q;

endmodule

`default_nettype wire

[rtl/core/cdq_checker.sv]
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        ok_o,
  input wire logic signed [WORD_BITS-1:0] read_value_o,
  input wire logic [OCC_BITS-1:0]         occupancy_o
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // occupancy never exceeds the capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= OCC_BITS'(DEPTH))
    else $error("occupancy above capacity");

  // a failed request reads nothing
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_value_o == '0)
    else $error("failed request returned a word");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ok_o         (ok_o),
  .read_value_o (read_value_o),
  .occupancy_o  (occupancy_o)
);

`default_nettype wire
